FILE: hdl/dfd_pkg.sv
// Shared types, widths and codes for the squared discrete Frechet distance core.
`default_nettype none

package dfd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int DIST_W     = 33;
    localparam int ERR_W      = 2;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ABS_W      = COORD_BITS + 1;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int CMP_W      = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ORDER    = 2'd2;

    typedef struct packed {
        logic                         curve_select;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } t_in_beat;

    typedef struct packed {
        logic [DIST_W-1:0] distance_sq;
        logic [ERR_W-1:0]  error_code;
    } t_out_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             fin;
        logic [CNT_W-1:0] hops;
        t_point           pt;
    } t_tok;

    typedef struct packed {
        logic [DIST_W-1:0] row;
        logic [DIST_W-1:0] prev;
    } t_link;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dsq;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/dfd_cell.sv
// One cell of the coupling row: holds a first-curve point and its column value.
`default_nettype none

module dfd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head,
    input  logic           i_pt_we,
    input  dfd_pkg::t_point i_pt,
    input  dfd_pkg::t_tok  i_tok,
    output dfd_pkg::t_tok  o_tok,
    input  dfd_pkg::t_link i_left,
    output dfd_pkg::t_link o_link,
    input  dfd_pkg::t_res  i_res,
    output dfd_pkg::t_res  o_res
);
    import dfd_pkg::*;

    function automatic logic [DIST_W-1:0] umax(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [DIST_W-1:0] umin(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    t_point            r_pt;
    t_tok              r_tok;
    logic              r_sv;
    logic              r_sfirst;
    logic              r_shit;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [DIST_W-1:0] r_row;
    logic [DIST_W-1:0] r_prev;
    t_res              r_res;

    logic [ABS_W-1:0]  dx;
    logic [ABS_W-1:0]  dy;
    logic [ABS_W-1:0]  ax;
    logic [ABS_W-1:0]  ay;
    logic [SQ_W-1:0]   n_sqx;
    logic [SQ_W-1:0]   n_sqy;
    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] n_row;
    t_res              n_res;

    always_comb begin
        dx = {r_tok.pt.x[COORD_BITS-1], r_tok.pt.x} - {r_pt.x[COORD_BITS-1], r_pt.x};
        dy = {r_tok.pt.y[COORD_BITS-1], r_tok.pt.y} - {r_pt.y[COORD_BITS-1], r_pt.y};
        ax = dx[ABS_W-1] ? (~dx + 1'b1) : dx;
        ay = dy[ABS_W-1] ? (~dy + 1'b1) : dy;
        n_sqx = SQ_W'(ax) * SQ_W'(ax);
        n_sqy = SQ_W'(ay) * SQ_W'(ay);
    end

    always_comb begin
        sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);
        d = (CMP_W'(sum) > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
        if (i_head) begin
            n_row = r_sfirst ? d : umax(r_row, d);
        end else if (r_sfirst) begin
            n_row = umax(i_left.row, d);
        end else begin
            n_row = umax(umin(umin(r_row, i_left.prev), i_left.row), d);
        end
        if (r_sv && r_shit) begin
            n_res.valid = 1'b1;
            n_res.dsq   = n_row;
        end else begin
            n_res = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt_we) begin
            r_pt <= i_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_sv  <= 1'b0;
            r_res <= '0;
        end else begin
            r_tok <= i_tok;
            r_sv  <= r_tok.valid;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sfirst <= r_tok.first;
        r_shit   <= r_tok.fin && (r_tok.hops == '0);
        r_sqx    <= n_sqx;
        r_sqy    <= n_sqy;
        if (r_sv) begin
            r_row  <= n_row;
            r_prev <= r_row;
        end
    end

    always_comb begin
        o_tok      = r_tok;
        o_tok.hops = r_tok.hops - 1'b1;
    end

    assign o_link.row  = r_row;
    assign o_link.prev = r_prev;
    assign o_res       = r_res;

endmodule

`default_nettype wire

FILE: hdl/discrete_frechet_distance_sq_core.sv
// Top level: curve loading, sequencing of the cell chain and the result register.
//
//  channel | direction | payload     | handshake
//  in      | input     | t_in_beat   | i_in_valid / o_in_stall
//  out     | output    | t_out_beat  | o_out_valid / i_out_stall
//
// A beat is taken in any cycle without input stall; second-curve points enter the cell
// chain back to back and move one cell per cycle. After the closing point of the second
// curve the result runs down the whole chain to the result register, then the output register;
// input stall holds until it is in the output register.
// Reset is synchronous, active low; it clears the control state only.
// A beat that ends a pair with an error code stalls while the output is held.
`default_nettype none

module discrete_frechet_distance_sq_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dfd_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dfd_pkg::t_out_beat o_out_data
);
    import dfd_pkg::*;

    logic              r_closed;
    logic [CNT_W-1:0]  r_fcnt;
    logic [CNT_W-1:0]  r_scnt;
    logic              r_err;
    logic              r_wait;
    logic              r_fin_v;
    logic [DIST_W-1:0] r_fin_d;
    logic              r_out_v;
    t_out_beat         r_out;

    logic              n_closed;
    logic [CNT_W-1:0]  n_fcnt;
    logic [CNT_W-1:0]  n_scnt;
    logic              n_err;
    logic              n_wait;
    logic              n_fin_v;
    logic [DIST_W-1:0] n_fin_d;
    logic              n_out_v;
    t_out_beat         n_out;

    logic              out_busy;
    logic              wrong_order;
    logic              err_n;
    logic              fin;
    logic              fin_bad;
    logic              emit_now;
    logic              acc;
    logic              load_pt;
    logic              launch;

    t_tok              w_tok  [0:MAX_POINTS];
    t_link             w_link [0:MAX_POINTS];
    t_res              w_res  [0:MAX_POINTS];
    logic [MAX_POINTS-1:0] w_pt_we;
    t_point            w_pt;

    always_comb begin
        out_busy    = r_out_v && i_out_stall;
        wrong_order = r_closed ? !i_in_data.curve_select : i_in_data.curve_select;
        err_n       = r_err || (r_closed && (r_scnt >= CNT_W'(MAX_POINTS)));
        fin         = r_closed && i_in_data.curve_select && i_in_data.last_point;
        fin_bad     = fin && (err_n || (r_fcnt == '0));
        emit_now    = wrong_order || fin_bad;
        o_in_stall  = r_wait || (emit_now && out_busy);
        acc         = i_in_valid && !o_in_stall;
        load_pt     = acc && !r_closed && !i_in_data.curve_select;
        launch      = acc && r_closed && i_in_data.curve_select && !err_n;
    end

    assign w_pt.x = i_in_data.point_x;
    assign w_pt.y = i_in_data.point_y;

    always_comb begin
        w_tok[0].valid = launch;
        w_tok[0].first = (r_scnt == '0);
        w_tok[0].fin   = i_in_data.last_point && (r_fcnt != '0);
        w_tok[0].hops  = r_fcnt - 1'b1;
        w_tok[0].pt    = w_pt;
    end

    assign w_link[0] = '0;
    assign w_res[0]  = '0;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        assign w_pt_we[g] = load_pt && (r_fcnt == CNT_W'(g));

        dfd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_head  (1'(g == 0)),
            .i_pt_we (w_pt_we[g]),
            .i_pt    (w_pt),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_left  (w_link[g]),
            .o_link  (w_link[g+1]),
            .i_res   (w_res[g]),
            .o_res   (w_res[g+1])
        );
    end

    always_comb begin
        n_closed = r_closed;
        n_fcnt   = r_fcnt;
        n_scnt   = r_scnt;
        n_err    = r_err;
        n_wait   = r_wait;
        n_fin_v  = r_fin_v;
        n_fin_d  = r_fin_d;
        n_out_v  = r_out_v && i_out_stall;
        n_out    = r_out;

        if (acc) begin
            if (emit_now) begin
                n_closed = 1'b0;
                n_fcnt   = '0;
                n_scnt   = '0;
                n_err    = 1'b0;
                n_out_v  = 1'b1;
                n_out.distance_sq = '0;
                n_out.error_code  = (!wrong_order && err_n) ? ERR_TOO_MANY : ERR_ORDER;
            end else if (!r_closed) begin
                if (r_fcnt < CNT_W'(MAX_POINTS)) begin
                    n_fcnt = r_fcnt + 1'b1;
                end else begin
                    n_err = 1'b1;
                end
                if (i_in_data.last_point) begin
                    n_closed = 1'b1;
                    n_scnt   = '0;
                end
            end else begin
                n_err = err_n;
                if (!err_n) begin
                    n_scnt = r_scnt + 1'b1;
                end
                if (i_in_data.last_point) begin
                    n_closed = 1'b0;
                    n_fcnt   = '0;
                    n_scnt   = '0;
                    n_err    = 1'b0;
                    n_wait   = 1'b1;
                end
            end
        end

        if (w_res[MAX_POINTS].valid) begin
            n_fin_v = 1'b1;
            n_fin_d = w_res[MAX_POINTS].dsq;
        end else if (r_fin_v && !out_busy) begin
            n_fin_v = 1'b0;
            n_wait  = 1'b0;
            n_out_v = 1'b1;
            n_out.distance_sq = r_fin_d;
            n_out.error_code  = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= 1'b0;
            r_fcnt   <= '0;
            r_scnt   <= '0;
            r_err    <= 1'b0;
            r_wait   <= 1'b0;
            r_fin_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_closed <= n_closed;
            r_fcnt   <= n_fcnt;
            r_scnt   <= n_scnt;
            r_err    <= n_err;
            r_wait   <= n_wait;
            r_fin_v  <= n_fin_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin_d <= n_fin_d;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: sim/discrete_frechet_distance_sq_core_tb.sv
// Self-checking testbench for the squared discrete Frechet distance core.
`timescale 1ns / 1ps

module discrete_frechet_distance_sq_core_tb;
    import dfd_pkg::*;

    localparam int LONG_HOLD = 400;

    typedef enum int {CO_FULL, CO_NEAR, CO_EDGE} coord_mode_t;
    typedef enum int {PK_GOOD, PK_OVERFLOW_A, PK_OVERFLOW_B, PK_EARLY_B, PK_LATE_A, PK_NOISE}
        pair_kind_t;

    typedef struct {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } vec_row_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    discrete_frechet_distance_sq_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_point          curve_a_pts [MAX_POINTS];
    longint unsigned coupling [MAX_POINTS];
    int              pts_loaded = 0;
    int              rows_done = 0;
    bit              too_many = 1'b0;
    bit              curve_a_closed = 1'b0;

    t_out_beat       pending_results [$];
    vec_row_t        vec_tbl [$];
    int              fail_count = 0;
    int              beats_sent = 0;
    int              snd_idle = 0;
    int              rcv_idle = 0;
    logic            hold_on = 1'b0;
    event            hold_go;
    t_out_beat       got_beat;
    t_out_beat       want_beat;

    task automatic report_miss(input string what, input longint unsigned got,
                               input longint unsigned want);
        fail_count++;
        $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic t_out_beat close_pair(longint unsigned dsq, logic [ERR_W-1:0] code);
        t_out_beat r;
        r.distance_sq  = DIST_W'(dsq);
        r.error_code   = code;
        pts_loaded     = 0;
        rows_done      = 0;
        too_many       = 1'b0;
        curve_a_closed = 1'b0;
        return r;
    endfunction

    task automatic frechet_step(input t_in_beat b, output bit has_res, output t_out_beat res);
        t_point          p;
        longint          dx;
        longint          dy;
        longint unsigned d;
        longint unsigned up;
        longint unsigned up_left;
        longint unsigned best;
        longint unsigned nxt;
        has_res = 1'b0;
        res     = '0;
        p.x     = b.point_x;
        p.y     = b.point_y;
        if (!curve_a_closed) begin
            if (b.curve_select) begin
                has_res = 1'b1;
                res     = close_pair(0, ERR_ORDER);
                return;
            end
            if (pts_loaded < MAX_POINTS) begin
                curve_a_pts[pts_loaded] = p;
                pts_loaded++;
            end else begin
                too_many = 1'b1;
            end
            if (b.last_point) begin
                curve_a_closed = 1'b1;
                rows_done      = 0;
            end
            return;
        end
        if (!b.curve_select) begin
            has_res = 1'b1;
            res     = close_pair(0, ERR_ORDER);
            return;
        end
        if (rows_done >= MAX_POINTS)
            too_many = 1'b1;
        if (!too_many) begin
            up_left = 0;
            for (int i = 0; i < pts_loaded; i++) begin
                dx = longint'(curve_a_pts[i].x) - longint'(p.x);
                dy = longint'(curve_a_pts[i].y) - longint'(p.y);
                d  = longint'(dx * dx + dy * dy);
                up = coupling[i];
                if (rows_done == 0) begin
                    if (i == 0)
                        nxt = d;
                    else
                        nxt = (coupling[i-1] > d) ? coupling[i-1] : d;
                end else if (i == 0) begin
                    nxt = (up > d) ? up : d;
                end else begin
                    best = (up < up_left) ? up : up_left;
                    best = (coupling[i-1] < best) ? coupling[i-1] : best;
                    nxt  = (best > d) ? best : d;
                end
                up_left     = up;
                coupling[i] = nxt;
            end
            rows_done++;
        end
        if (b.last_point) begin
            has_res = 1'b1;
            if (too_many || pts_loaded == 0)
                res = close_pair(0, too_many ? ERR_TOO_MANY : ERR_ORDER);
            else
                res = close_pair(coupling[pts_loaded-1], ERR_OK);
        end
    endtask

    task automatic send_beat(input t_in_beat b, input logic typed, input t_out_beat want);
        bit        has;
        t_out_beat r;
        if (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        frechet_step(b, has, r);
        if (typed)
            pending_results.push_back(want);
        else if (has)
            pending_results.push_back(r);
        beats_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(coord_mode_t m);
        case (m)
            CO_FULL: return COORD_BITS'($urandom_range(65535));
            CO_NEAR: return COORD_BITS'(int'($urandom_range(16)) - 8);
            default: begin
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_beat mk_beat(logic sel, logic last, coord_mode_t m);
        t_in_beat b;
        b.curve_select = sel;
        b.point_x      = pick_coord(m);
        b.point_y      = pick_coord(m);
        b.last_point   = last;
        return b;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(4, 1);
        if (r < 90)
            return $urandom_range(16, 5);
        return $urandom_range(MAX_POINTS, 17);
    endfunction

    function automatic pair_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 74) return PK_GOOD;
        if (r < 80) return PK_OVERFLOW_A;
        if (r < 85) return PK_OVERFLOW_B;
        if (r < 90) return PK_EARLY_B;
        if (r < 95) return PK_LATE_A;
        return PK_NOISE;
    endfunction

    task automatic send_curve(input logic sel, input int n, input coord_mode_t m);
        for (int k = 0; k < n; k++)
            send_beat(mk_beat(sel, k == n - 1, m), 1'b0, '0);
    endtask

    task automatic send_pair(input pair_kind_t kind);
        coord_mode_t m;
        int          n;
        m = coord_mode_t'($urandom_range(2));
        case (kind)
            PK_GOOD: begin
                send_curve(1'b0, pick_len(), m);
                send_curve(1'b1, pick_len(), m);
            end
            PK_OVERFLOW_A: begin
                send_curve(1'b0, MAX_POINTS + $urandom_range(6, 1), m);
                send_curve(1'b1, pick_len(), m);
            end
            PK_OVERFLOW_B: begin
                send_curve(1'b0, pick_len(), m);
                send_curve(1'b1, MAX_POINTS + $urandom_range(6, 1), m);
            end
            PK_EARLY_B: begin
                n = $urandom_range(3);
                for (int k = 0; k < n; k++)
                    send_beat(mk_beat(1'b0, 1'b0, m), 1'b0, '0);
                send_beat(mk_beat(1'b1, 1'($urandom_range(1)), m), 1'b0, '0);
            end
            PK_LATE_A: begin
                send_curve(1'b0, pick_len(), m);
                n = $urandom_range(3);
                for (int k = 0; k < n; k++)
                    send_beat(mk_beat(1'b1, 1'b0, m), 1'b0, '0);
                send_beat(mk_beat(1'b0, 1'($urandom_range(1)), m), 1'b0, '0);
            end
            default: begin
                n = $urandom_range(4, 1);
                for (int k = 0; k < n; k++)
                    send_beat(mk_beat(1'($urandom_range(1)), 1'($urandom_range(1)), m),
                              1'b0, '0);
            end
        endcase
    endtask

    function automatic vec_row_t vec(logic sel, logic signed [COORD_BITS-1:0] x,
                                     logic signed [COORD_BITS-1:0] y, logic last,
                                     logic typed, logic [DIST_W-1:0] dsq,
                                     logic [ERR_W-1:0] err);
        vec_row_t v;
        v.beat.curve_select = sel;
        v.beat.point_x      = x;
        v.beat.point_y      = y;
        v.beat.last_point   = last;
        v.typed             = typed;
        v.want.distance_sq  = dsq;
        v.want.error_code   = err;
        return v;
    endfunction

    // receiver: random stall, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_on || ($urandom_range(99) < rcv_idle);
        end
    end

    initial begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got_beat = o_out_data;
            if (pending_results.size() == 0) begin
                report_miss("result with nothing pending", got_beat.distance_sq, 0);
            end else begin
                want_beat = pending_results.pop_front();
                if (got_beat.distance_sq !== want_beat.distance_sq)
                    report_miss("distance_sq", got_beat.distance_sq, want_beat.distance_sq);
                if (got_beat.error_code !== want_beat.error_code)
                    report_miss("error_code", got_beat.error_code, want_beat.error_code);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        vec_tbl.push_back(vec(1'b1, 16'sh0000, 16'sh0000, 1'b0, 1'b1, 33'd0, ERR_ORDER));
        vec_tbl.push_back(vec(1'b0, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 33'd8589672450,
                              ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh0001, 16'sh0001, 1'b0, 1'b1, 33'd0, ERR_ORDER));
        vec_tbl.push_back(vec(1'b0, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'shffff, 16'sh0000, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh0005, 16'sh0007, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh8000, 16'sh7fff, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh0003, 16'shfffc, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh0064, 16'shff9c, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh0002, 16'sh0002, 1'b1, 1'b1, 33'd0, ERR_ORDER));
        vec_tbl.push_back(vec(1'b0, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh0000, 16'sh0000, 1'b1, 1'b1, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh0001, 16'sh0002, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh0003, 16'sh0004, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh0001, 16'sh0002, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh0003, 16'sh0004, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh8000, 16'sh7fff, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b1, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, 33'd0, ERR_OK));
        vec_tbl.push_back(vec(1'b0, 16'sh1234, 16'sh5678, 1'b1, 1'b1, 33'd0, ERR_ORDER));

        snd_idle = 29;
        rcv_idle = 59;
        foreach (vec_tbl[k])
            send_beat(vec_tbl[k].beat, vec_tbl[k].typed, vec_tbl[k].want);

        send_pair(PK_OVERFLOW_A);
        send_pair(PK_OVERFLOW_B);
        while (beats_sent < 240)
            send_pair(pick_kind());

        // hold the sender until every expected result has come back
        drain_results();

        snd_idle = 59;
        rcv_idle = 29;
        while (beats_sent < 460)
            send_pair(pick_kind());

        snd_idle = 0;
        rcv_idle = 0;
        -> hold_go;
        while (beats_sent < 650)
            send_pair(pick_kind());

        drain_results();
        repeat (MAX_POINTS + 16) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
